>>> rtl/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes, widths and the cell token type.
// No dependencies.
package fpa_pkg;
    localparam int unsigned DataWidth        = 32;
    localparam int unsigned FractionBitsDflt = 8;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
        OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
    } t_opcode;

    // Token carried along the divider chain: restoring division on magnitudes.
    typedef struct packed {
        logic                   vld;
        logic                   is_div;
        logic                   neg;
        logic                   err;
        logic [DataWidth-1:0]   res;
        logic                   cmp;
        logic [DataWidth+29:0]  rem;  // partial remainder
        logic [DataWidth+29:0]  quo;  // dividend bits shifting out, quotient in
        logic [DataWidth-1:0]   dvs;  // divisor magnitude
    } t_token;
endpackage

>>> rtl/fpa_cell.sv
// One cell of the divider chain: one restoring quotient bit per cycle while enabled.
// Depends on fpa_pkg.
module fpa_cell import fpa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_token i_tok,
    output t_token o_tok
);
    t_token r_tok;
    t_token n_tok;
    logic [DataWidth+30:0] w_trial;

    always_comb begin
        n_tok   = i_tok;
        w_trial = {i_tok.rem, i_tok.quo[DataWidth+29]} - {31'd0, i_tok.dvs};
        if (i_tok.is_div) begin
            if (!w_trial[DataWidth+30]) begin
                n_tok.rem = w_trial[DataWidth+29:0];
                n_tok.quo = {i_tok.quo[DataWidth+28:0], 1'b1};
            end else begin
                n_tok.rem = {i_tok.rem[DataWidth+28:0], i_tok.quo[DataWidth+29]};
                n_tok.quo = {i_tok.quo[DataWidth+28:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok.vld <= i_tok.vld;
        end
        if (i_en) begin
            r_tok.is_div <= n_tok.is_div;
            r_tok.neg    <= n_tok.neg;
            r_tok.err    <= n_tok.err;
            r_tok.res    <= n_tok.res;
            r_tok.cmp    <= n_tok.cmp;
            r_tok.rem    <= n_tok.rem;
            r_tok.quo    <= n_tok.quo;
            r_tok.dvs    <= n_tok.dvs;
        end
    end

    assign o_tok = r_tok;
endmodule

>>> rtl/fpa_front.sv
// Entry stages: all non-divide operations, registered multiply, divider token setup.
// Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; #(
    parameter int unsigned FRACTION_BITS = FractionBitsDflt
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [3:0]                  i_opcode,
    input  logic signed [DataWidth-1:0] i_operand_a,
    input  logic signed [DataWidth-1:0] i_operand_b,
    output t_token                      o_tok
);
    localparam int unsigned QW = DataWidth + 30;

    t_opcode                      w_op;
    logic                         r_vld;
    t_opcode                      r_op;
    logic signed [DataWidth-1:0]  r_a;
    logic signed [DataWidth-1:0]  r_b;
    logic signed [2*DataWidth-1:0] r_prod;
    logic signed [2*DataWidth-1:0] w_prod_sh;
    logic [DataWidth-1:0]         w_res;
    logic                         w_cmp;
    logic [DataWidth-1:0]         w_amag;
    logic [DataWidth-1:0]         w_bmag;
    logic [QW-1:0]                w_dvd;
    t_token                       n_tok;
    t_token                       r_tok;

    assign w_op = t_opcode'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_op   <= w_op;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_prod <= (2*DataWidth)'(i_operand_a) * (2*DataWidth)'(i_operand_b);
        end
    end

    assign w_prod_sh = r_prod >>> FRACTION_BITS;
    assign w_amag    = r_a[DataWidth-1] ? DataWidth'(-r_a) : r_a;
    assign w_bmag    = r_b[DataWidth-1] ? DataWidth'(-r_b) : r_b;
    assign w_dvd     = QW'(w_amag) << FRACTION_BITS;

    always_comb begin
        w_res = '0;
        w_cmp = 1'b0;
        case (r_op)
            OP_ADD:     w_res = r_a + r_b;
            OP_SUB:     w_res = r_a - r_b;
            OP_MUL:     w_res = w_prod_sh[DataWidth-1:0];
            OP_DIV:     w_res = '0;
            OP_GT:      w_cmp = r_a > r_b;
            OP_LT:      w_cmp = r_a < r_b;
            OP_GE:      w_cmp = r_a >= r_b;
            OP_LE:      w_cmp = r_a <= r_b;
            OP_EQ:      w_cmp = r_a == r_b;
            OP_NE:      w_cmp = r_a != r_b;
            OP_MIN:     w_res = (r_a < r_b) ? r_a : r_b;
            OP_MAX:     w_res = (r_a > r_b) ? r_a : r_b;
            OP_INC:     w_res = r_a + DataWidth'(1);
            OP_DEC:     w_res = r_a - DataWidth'(1);
            OP_TOINT:   w_res = r_a >>> FRACTION_BITS;
            OP_FROMINT: w_res = r_a << FRACTION_BITS;
            default:    w_res = '0;
        endcase
    end

    always_comb begin
        n_tok        = '0;
        n_tok.vld    = r_vld;
        n_tok.res    = w_res;
        n_tok.cmp    = w_cmp;
        n_tok.err    = (r_op == OP_DIV) && (r_b == '0);
        n_tok.is_div = (r_op == OP_DIV) && (r_b != '0);
        n_tok.neg    = r_a[DataWidth-1] ^ r_b[DataWidth-1];
        n_tok.quo    = w_dvd;
        n_tok.dvs    = w_bmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok.vld <= n_tok.vld;
        end
        if (i_en) begin
            r_tok.is_div <= n_tok.is_div;
            r_tok.neg    <= n_tok.neg;
            r_tok.err    <= n_tok.err;
            r_tok.res    <= n_tok.res;
            r_tok.cmp    <= n_tok.cmp;
            r_tok.rem    <= n_tok.rem;
            r_tok.quo    <= n_tok.quo;
            r_tok.dvs    <= n_tok.dvs;
        end
    end

    assign o_tok = r_tok;
endmodule

>>> rtl/fixed_point_alu_core.sv
// Pipeline: two entry stages, 62 divider cells, output register.
// Throughput: one transfer per cycle unless the output is held; every operation flows through the cell chain.
// The whole chain stalls together when the output is held.
// Reset: synchronous, active low; clears all valid flags, payload is not reset.
// Top level of the fixed-point ALU. Depends on fpa_pkg, fpa_front, fpa_cell.
module fixed_point_alu_core import fpa_pkg::*; #(
    parameter int unsigned FRACTION_BITS = FractionBitsDflt
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [3:0]                   i_opcode,
    input  logic signed [DataWidth-1:0]  i_operand_a,
    input  logic signed [DataWidth-1:0]  i_operand_b,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DataWidth-1:0]  o_result_value,
    output logic                         o_compare_true,
    output logic                         o_divide_error
);
    localparam int unsigned NCells = DataWidth + 30;

    logic   w_en;
    t_token w_chain [NCells+1];
    logic [DataWidth-1:0] w_q;
    logic                 r_vld;
    logic [DataWidth-1:0] r_res;
    logic                 r_cmp;
    logic                 r_err;
    t_token               w_last;

    assign w_en    = !r_vld || i_ready;
    assign o_ready = w_en;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_tok       (w_chain[0])
    );

    for (genvar g = 0; g < NCells; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1])
        );
    end

    assign w_last = w_chain[NCells];
    assign w_q    = w_last.neg ? DataWidth'(-w_last.quo[DataWidth-1:0])
                               : w_last.quo[DataWidth-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_last.vld;
        end
        if (w_en) begin
            r_res <= w_last.is_div ? w_q : w_last.res;
            r_cmp <= w_last.cmp;
            r_err <= w_last.err;
        end
    end

    assign o_valid        = r_vld;
    assign o_result_value = r_res;
    assign o_compare_true = r_cmp;
    assign o_divide_error = r_err;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_result_value == '0 && !o_compare_true)
        else $error("divide error with non-zero result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("output changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("stall without pending output");
`endif
endmodule
